/* rtl/bfsa_pkg.sv */
// ----------------------------------------------------------------------------
// bfsa_pkg - shared definitions for the slot allocator
// Field widths, register indexes, opcodes, status codes and reset values.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int INDEX_W   = 10;
    localparam int STRIDE_W  = 13;
    localparam int LIMIT_W   = 11;
    localparam int ADDR_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int LIVE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = INDEX_W + STRIDE_W;

    localparam int POOL_DEPTH_DEFAULT = 1024;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_STRIDE = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_FREE_NONE = 2'd2
    } status_t;

endpackage

/* rtl/bfsa_ram.sv */
// ----------------------------------------------------------------------------
// bfsa_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bump_and_free_stack_index_allocator_top.sv */
// ----------------------------------------------------------------------------
// bump_and_free_stack_index_allocator_top - slot allocator, fresh then LIFO
// Hands out fresh slot indexes in ascending order up to the limit, then
// reuses freed slots most recently freed first. Reports index, address,
// status and live count for every item.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | op, release_index
//  out     | out_valid / out_stall| granted_index, granted_address, status,
//          |                      | live_count
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; its result is valid in the cycle after acceptance.
//  The stack top sits in a register, the entry below it is prefetched from
//  the stack RAM every cycle, so back-to-back pops do not stall the input.
//  in_stall is high while a result is held under out_stall.
//  Reset clears counters and loads register defaults; the stack RAM is
//  not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module bump_and_free_stack_index_allocator_top
    import bfsa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [INDEX_W-1:0]   release_index,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [INDEX_W-1:0]   granted_index,
    output logic [ADDR_W-1:0]    granted_address,
    output logic [STATUS_W-1:0]  status,
    output logic [LIVE_W-1:0]    live_count,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // configuration
    logic [ADDR_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // allocator state
    logic [CNT_W-1:0]    fresh_reg,  fresh_next;
    logic [CNT_W-1:0]    depth_reg,  depth_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [INDEX_W-1:0]  top_reg,    top_next;

    // result register
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  idx_reg,    idx_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;
    status_t             status_reg, status_next;
    logic [LIVE_W-1:0]   live_reg;

    logic                in_accept;
    logic                fresh_ok;
    logic                push;
    logic                pop;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [AW-1:0]       ram_rd_addr;
    logic [INDEX_W-1:0]  second_data;
    logic [PROD_W-1:0]   product;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            stride_reg <= STRIDE_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE:   base_reg   <= cfg_data;
                CFG_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign fresh_ok = (CMP_W'(fresh_reg) < CMP_W'(limit_reg))
                   && (CMP_W'(fresh_reg) < CMP_W'(POOL_DEPTH));

    always_comb
    begin
        fresh_next  = fresh_reg;
        depth_next  = depth_reg;
        active_next = active_reg;
        top_next    = top_reg;
        idx_next    = '0;
        status_next = ST_OK;
        push        = 1'b0;
        pop         = 1'b0;

        if (in_accept)
        begin
            if (op == OP_ALLOC)
            begin
                if (fresh_ok)
                begin
                    idx_next    = INDEX_W'(fresh_reg);
                    fresh_next  = fresh_reg + CNT_W'(1);
                    active_next = active_reg + CNT_W'(1);
                end
                else if (depth_reg != '0)
                begin
                    pop         = 1'b1;
                    idx_next    = top_reg;
                    depth_next  = depth_reg - CNT_W'(1);
                    top_next    = second_data;
                    active_next = active_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NO_SLOT;
                end
            end
            else
            begin
                if (active_reg == '0)
                begin
                    status_next = ST_FREE_NONE;
                end
                else
                begin
                    active_next = active_reg - CNT_W'(1);
                    if (CMP_W'(depth_reg) < CMP_W'(POOL_DEPTH))
                    begin
                        push       = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                        top_next   = release_index;
                    end
                end
            end
        end
    end

    assign product   = PROD_W'(idx_next) * PROD_W'(stride_reg);
    assign addr_next = (status_next == ST_OK && (in_accept && op == OP_ALLOC))
                     ? base_reg + ADDR_W'(product) : '0;

    // full copy of the stack lives in RAM; read side always holds the entry
    // just below the top for the next cycle
    assign ram_wr_en   = push;
    assign ram_wr_addr = AW'(depth_reg);
    assign ram_rd_addr = AW'(depth_next - CNT_W'(2));

    bfsa_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (release_index),
        .rd_addr (ram_rd_addr),
        .rd_data (second_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= '0;
            depth_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg  <= fresh_next;
            depth_reg  <= depth_next;
            active_reg <= active_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (in_accept)
        begin
            idx_reg    <= idx_next;
            addr_reg   <= addr_next;
            status_reg <= status_next;
            live_reg   <= LIVE_W'(active_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_index   = idx_reg;
    assign granted_address = addr_reg;
    assign status          = status_reg;
    assign live_count      = live_reg;

`ifndef NO_ASSERTIONS
    // every fresh slot is either live or sitting on the stack
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(active_reg) + (CNT_W + 1)'(depth_reg) == (CNT_W + 1)'(fresh_reg))
        else $error("live count plus stack depth differs from fresh cursor");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fresh_reg) <= CMP_W'(POOL_DEPTH))
        else $error("fresh cursor beyond pool");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(depth_reg) && $stable(active_reg) && $stable(fresh_reg))
        else $error("allocator state moved without an item");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in one cycle");

    a_pop_top: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && idx_reg == $past(top_reg))
        else $error("pop did not return the stack top");
`endif

endmodule
